FILE: rtl/xcfd_pkg.sv
// Shared types, constants and codes for the XOR checksum frame deframer.
package xcfd_pkg;

   localparam int MAX_PAYLOAD = 64;
   localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int COUNT_W     = $clog2(MAX_PAYLOAD + 1);

   localparam int BYTE_W   = 8;
   localparam int LIMIT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 6;
   localparam int CSR_IDX_W = 1;

   localparam logic [BYTE_W-1:0]  START_BYTE_RESET   = 8'hAA;
   localparam logic [LIMIT_W-1:0] LENGTH_LIMIT_RESET = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_LIMIT = 1'd1;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CSUM   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LENGTH = 2'd2;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_TYPE,
      ST_LENGTH,
      ST_PAYLOAD,
      ST_CHECK,
      ST_REPLAY_READ,
      ST_REPLAY_EMIT
   } state_type;

   typedef enum logic [1:0] {
      RES_OK_BYTE,
      RES_OK_EMPTY,
      RES_CSUM,
      RES_LENGTH
   } result_kind_type;

   typedef struct packed {
      logic            clear;
      logic            load_type;
      logic            load_length;
      logic            store_byte;
      logic            replay_start;
      logic            replay_next;
      logic            out_load;
      result_kind_type out_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_start;
      logic len_over;
      logic byte_zero;
      logic payload_done;
      logic csum_ok;
      logic frame_empty;
      logic replay_last;
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/xor_checksum_frame_deframer_unit.sv
// Top level of the start/type/length/payload/XOR-checksum frame deframer.
//
// Input channel (req_): one received link byte per transaction, taken at a
// clock edge with req_valid high and req_stall low. Header and payload bytes
// are taken one per cycle while the result slot is free.
// Result channel (rsp_): one result per transaction, held in an output
// register until taken (rsp_valid high, rsp_stall low).
// A length-error, checksum-error or empty-frame result is loaded into the output
// register when the byte that causes it is taken. The payload of a good frame is
// replayed from the 64-entry payload buffer: each result takes a buffer read,
// then a load of the output register, and req_stall stays high through the whole
// replay, including any receiver stall.
// The replay pace is set by the single read port and its registered read data.
// A receiver stall holds the current result; while it is held, req_stall is
// high as well, so no byte is taken until that result leaves.
// Reset (synchronous, active high) returns the parser to hunting for the start
// byte, drops any pending result and restores start_byte = 0xAA and
// length_limit = 64. The buffer itself is not cleared; only entries written in
// the current frame are ever read. csr_ writes take effect at once, no wait.
module xor_checksum_frame_deframer_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [xcfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [xcfd_pkg::BYTE_W-1:0]    csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [xcfd_pkg::BYTE_W-1:0]    req_byte_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [xcfd_pkg::STATUS_W-1:0]  rsp_out_status,
   output logic [xcfd_pkg::BYTE_W-1:0]    rsp_out_type,
   output logic [xcfd_pkg::BYTE_W-1:0]    rsp_out_length,
   output logic [xcfd_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic [xcfd_pkg::INDEX_W-1:0]   rsp_out_index,
   output logic                           rsp_has_byte,
   output logic                           rsp_last_of_run
);

   // command and status between sequencer and datapath
   xcfd_pkg::ctrl_cmd_type  cmd;
   xcfd_pkg::dp_status_type status;

   xcfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   xcfd_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_byte_in     (req_byte_in),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_out_status  (rsp_out_status),
      .rsp_out_type    (rsp_out_type),
      .rsp_out_length  (rsp_out_length),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_index   (rsp_out_index),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

FILE: rtl/xcfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module xcfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/xcfd_ctrl.sv
// Frame parser state machine: sequences header, payload, check and replay.
module xcfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  xcfd_pkg::dp_status_type status,
   output xcfd_pkg::ctrl_cmd_type  cmd
);

   xcfd_pkg::state_type state_ff, state_in;
   logic                accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xcfd_pkg::ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   // no new byte while replaying or while the result slot is blocked
   assign req_stall = (state_ff == xcfd_pkg::ST_REPLAY_READ) ||
                      (state_ff == xcfd_pkg::ST_REPLAY_EMIT) || !status.out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.out_kind     = xcfd_pkg::RES_OK_BYTE;
      unique case (state_ff)
         xcfd_pkg::ST_HUNT: begin
            if (accept && status.is_start) begin
               state_in = xcfd_pkg::ST_TYPE;
            end
         end
         xcfd_pkg::ST_TYPE: begin
            if (accept) begin
               cmd.load_type = 1'b1;
               state_in      = xcfd_pkg::ST_LENGTH;
            end
         end
         xcfd_pkg::ST_LENGTH: begin
            if (accept) begin
               if (status.len_over) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = xcfd_pkg::RES_LENGTH;
                  cmd.clear    = 1'b1;
                  state_in     = xcfd_pkg::ST_HUNT;
               end else begin
                  cmd.load_length = 1'b1;
                  state_in = status.byte_zero ? xcfd_pkg::ST_CHECK : xcfd_pkg::ST_PAYLOAD;
               end
            end
         end
         xcfd_pkg::ST_PAYLOAD: begin
            if (accept) begin
               cmd.store_byte = 1'b1;
               if (status.payload_done) begin
                  state_in = xcfd_pkg::ST_CHECK;
               end
            end
         end
         xcfd_pkg::ST_CHECK: begin
            if (accept) begin
               priority if (!status.csum_ok) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = xcfd_pkg::RES_CSUM;
                  cmd.clear    = 1'b1;
                  state_in     = xcfd_pkg::ST_HUNT;
               end else if (status.frame_empty) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = xcfd_pkg::RES_OK_EMPTY;
                  cmd.clear    = 1'b1;
                  state_in     = xcfd_pkg::ST_HUNT;
               end else begin
                  cmd.replay_start = 1'b1;
                  state_in         = xcfd_pkg::ST_REPLAY_READ;
               end
            end
         end
         xcfd_pkg::ST_REPLAY_READ: begin
            state_in = xcfd_pkg::ST_REPLAY_EMIT;
         end
         xcfd_pkg::ST_REPLAY_EMIT: begin
            if (status.out_free) begin
               cmd.out_load    = 1'b1;
               cmd.out_kind    = xcfd_pkg::RES_OK_BYTE;
               cmd.replay_next = 1'b1;
               if (status.replay_last) begin
                  cmd.clear = 1'b1;
                  state_in  = xcfd_pkg::ST_HUNT;
               end else begin
                  state_in = xcfd_pkg::ST_REPLAY_READ;
               end
            end
         end
         default: begin
            state_in = xcfd_pkg::ST_HUNT;
         end
      endcase
   end

`ifndef SYNTH
   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded while output slot occupied and stalled");

   a_read_then_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == xcfd_pkg::ST_REPLAY_READ) |=> (state_ff == xcfd_pkg::ST_REPLAY_EMIT))
      else $error("replay read not followed by emit");

   a_replay_on_good_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.replay_start |-> (status.csum_ok && !status.frame_empty))
      else $error("replay started without matching checksum");
`endif

endmodule

FILE: rtl/xcfd_dpath.sv
// Datapath: config registers, frame registers, running XOR, buffer, result register.
module xcfd_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [xcfd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [xcfd_pkg::BYTE_W-1:0]            csr_wdata,
   input  logic [xcfd_pkg::BYTE_W-1:0]            req_byte_in,
   input  logic                                   rsp_stall,
   input  xcfd_pkg::ctrl_cmd_type                  cmd,
   output xcfd_pkg::dp_status_type                 status,
   output logic                                   rsp_valid,
   output logic [xcfd_pkg::STATUS_W-1:0]          rsp_out_status,
   output logic [xcfd_pkg::BYTE_W-1:0]            rsp_out_type,
   output logic [xcfd_pkg::BYTE_W-1:0]            rsp_out_length,
   output logic [xcfd_pkg::BYTE_W-1:0]            rsp_out_byte,
   output logic [xcfd_pkg::INDEX_W-1:0]           rsp_out_index,
   output logic                                   rsp_has_byte,
   output logic                                   rsp_last_of_run
);

   logic [xcfd_pkg::BYTE_W-1:0]  start_byte_ff;
   logic [xcfd_pkg::LIMIT_W-1:0] length_limit_ff;
   logic [xcfd_pkg::BYTE_W-1:0]  frame_type_ff;
   logic [xcfd_pkg::COUNT_W-1:0] frame_length_ff;
   logic [xcfd_pkg::COUNT_W-1:0] byte_count_ff;
   logic [xcfd_pkg::BYTE_W-1:0]  running_xor_ff;
   logic [xcfd_pkg::COUNT_W-1:0] replay_idx_ff;

   logic                          out_valid_ff;
   logic [xcfd_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic [xcfd_pkg::BYTE_W-1:0]   out_type_ff;
   logic [xcfd_pkg::BYTE_W-1:0]   out_length_ff, out_length_in;
   logic [xcfd_pkg::BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic [xcfd_pkg::INDEX_W-1:0]  out_index_ff, out_index_in;
   logic                          has_byte_ff, has_byte_in;
   logic                          last_ff, last_in;

   logic [xcfd_pkg::BYTE_W-1:0]  eff_limit;
   logic [xcfd_pkg::BYTE_W-1:0]  limit_ext;
   logic [xcfd_pkg::BYTE_W-1:0]  max_ext;
   logic [xcfd_pkg::COUNT_W:0]   count_next;
   logic [xcfd_pkg::COUNT_W:0]   idx_next;
   logic [xcfd_pkg::BYTE_W-1:0]  ram_rd_data;

   // effective limit never exceeds the buffer depth
   assign limit_ext  = xcfd_pkg::BYTE_W'(length_limit_ff);
   assign max_ext    = xcfd_pkg::BYTE_W'(xcfd_pkg::MAX_PAYLOAD);
   assign eff_limit  = (limit_ext > max_ext) ? max_ext : limit_ext;
   assign count_next = (xcfd_pkg::COUNT_W + 1)'(byte_count_ff) + 1'b1;
   assign idx_next   = (xcfd_pkg::COUNT_W + 1)'(replay_idx_ff) + 1'b1;

   always_comb begin
      status.is_start     = (req_byte_in == start_byte_ff);
      status.len_over     = (req_byte_in > eff_limit);
      status.byte_zero    = (req_byte_in == '0);
      status.payload_done = (count_next >= (xcfd_pkg::COUNT_W + 1)'(frame_length_ff));
      status.csum_ok      = (running_xor_ff == req_byte_in);
      status.frame_empty  = (frame_length_ff == '0);
      status.replay_last  = (idx_next == (xcfd_pkg::COUNT_W + 1)'(frame_length_ff));
      status.out_free     = !out_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff   <= xcfd_pkg::START_BYTE_RESET;
         length_limit_ff <= xcfd_pkg::LENGTH_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            xcfd_pkg::CSR_START_BYTE:   start_byte_ff   <= csr_wdata;
            xcfd_pkg::CSR_LENGTH_LIMIT: length_limit_ff <= csr_wdata[xcfd_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         frame_type_ff   <= '0;
         frame_length_ff <= '0;
         byte_count_ff   <= '0;
         running_xor_ff  <= '0;
      end else begin
         if (cmd.load_type) begin
            frame_type_ff  <= req_byte_in;
            running_xor_ff <= req_byte_in;
         end
         if (cmd.load_length) begin
            frame_length_ff <= xcfd_pkg::COUNT_W'(req_byte_in);
            byte_count_ff   <= '0;
            running_xor_ff  <= running_xor_ff ^ req_byte_in;
         end
         if (cmd.store_byte) begin
            byte_count_ff  <= count_next[xcfd_pkg::COUNT_W-1:0];
            running_xor_ff <= running_xor_ff ^ req_byte_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         replay_idx_ff <= '0;
      end else if (cmd.replay_start) begin
         replay_idx_ff <= '0;
      end else if (cmd.replay_next) begin
         replay_idx_ff <= idx_next[xcfd_pkg::COUNT_W-1:0];
      end
   end

   xcfd_ram #(
      .WIDTH (xcfd_pkg::BYTE_W),
      .DEPTH (xcfd_pkg::MAX_PAYLOAD)
   ) u_buf (
      .clock   (clock),
      .wr_en   (cmd.store_byte),
      .wr_addr (byte_count_ff[xcfd_pkg::ADDR_W-1:0]),
      .wr_data (req_byte_in),
      .rd_addr (replay_idx_ff[xcfd_pkg::ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      out_status_in = xcfd_pkg::STATUS_OK;
      out_length_in = xcfd_pkg::BYTE_W'(frame_length_ff);
      out_byte_in   = '0;
      out_index_in  = '0;
      has_byte_in   = 1'b0;
      last_in       = 1'b1;
      unique case (cmd.out_kind)
         xcfd_pkg::RES_OK_BYTE: begin
            out_byte_in  = ram_rd_data;
            out_index_in = xcfd_pkg::INDEX_W'(replay_idx_ff);
            has_byte_in  = 1'b1;
            last_in      = status.replay_last;
         end
         xcfd_pkg::RES_OK_EMPTY: begin
            out_status_in = xcfd_pkg::STATUS_OK;
         end
         xcfd_pkg::RES_CSUM: begin
            out_status_in = xcfd_pkg::STATUS_CSUM;
         end
         xcfd_pkg::RES_LENGTH: begin
            out_status_in = xcfd_pkg::STATUS_LENGTH;
            out_length_in = req_byte_in;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status_ff <= out_status_in;
         out_type_ff   <= frame_type_ff;
         out_length_ff <= out_length_in;
         out_byte_ff   <= out_byte_in;
         out_index_ff  <= out_index_in;
         has_byte_ff   <= has_byte_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_status  = out_status_ff;
   assign rsp_out_type    = out_type_ff;
   assign rsp_out_length  = out_length_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_out_index   = out_index_ff;
   assign rsp_has_byte    = has_byte_ff;
   assign rsp_last_of_run = last_ff;

`ifndef SYNTH
   a_store_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.store_byte |-> (count_next <= (xcfd_pkg::COUNT_W + 1)'(frame_length_ff)))
      else $error("payload write beyond frame length");
`endif

endmodule
